### design/rhsl_pkg.sv
`timescale 1ns / 1ps
package rhsl_pkg;

	// Scaling constants of the conversion.
	localparam logic [7:0] SCALE_MAX = 8'd255;
	localparam logic [7:0] HUE_STEP  = 8'd42;   // SCALE_MAX / 6
	localparam logic [7:0] HUE_GREEN = 8'd85;   // SCALE_MAX / 3
	localparam logic [7:0] HUE_BLUE  = 8'd170;  // 2 * SCALE_MAX / 3
	localparam logic [8:0] SUM_DARK_MAX = 9'd254; // sum at or below this gives lightness <= 127
	localparam logic [8:0] SUM_FULL  = 9'd510;  // 2 * SCALE_MAX

	// Divider geometry: 16-bit dividend, 9-bit divisor, quotient known to fit 8 bits.
	localparam int unsigned NUM_W          = 16;
	localparam int unsigned DEN_W          = 9;
	localparam int unsigned QUO_W          = 8;
	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

	// Divider lanes.
	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned LANE_SAT  = 0;
	localparam int unsigned LANE_DR   = 1;
	localparam int unsigned LANE_DG   = 2;
	localparam int unsigned LANE_DB   = 3;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} rhsl_max_t;

	// Per-item control that travels alongside the divider lanes.
	typedef struct packed {
		logic       valid;
		logic       grey;
		rhsl_max_t  max_sel;
		logic [7:0] light;
	} rhsl_tag_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} rhsl_div_t;

	typedef rhsl_div_t [NUM_LANES-1:0] rhsl_lanes_t;

	// One restoring division step for quotient bit bit_pos.
	function automatic rhsl_div_t rhsl_div_bit(input rhsl_div_t x, input logic [2:0] bit_pos);
		rhsl_div_t         y;
		logic [NUM_W:0]    shifted;
		y = x;
		shifted = {{(NUM_W + 1 - DEN_W){1'b0}}, x.den} << bit_pos;
		if ({1'b0, x.rem} >= shifted) begin
			y.rem = NUM_W'({1'b0, x.rem} - shifted);
			y.quo[bit_pos] = 1'b1;
		end
		return y;
	endfunction

endpackage

### design/rhsl_rgb_if.sv
`timescale 1ns / 1ps
interface rhsl_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/rhsl_hsl_if.sv
`timescale 1ns / 1ps
interface rhsl_hsl_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] lightness;

	modport source (output valid, output hue, output saturation, output lightness, input ready);
	modport sink   (input valid, input hue, input saturation, input lightness, output ready);
endinterface

### design/rhsl_prep.sv
`timescale 1ns / 1ps
module rhsl_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output rhsl_pkg::rhsl_tag_t  tag_s2,
	output rhsl_pkg::rhsl_lanes_t lanes_s2
);

	logic                valid_s1;
	logic [7:0]          r_s1, g_s1, b_s1, hi_s1, lo_s1;
	rhsl_pkg::rhsl_max_t max_s1;

	rhsl_pkg::rhsl_max_t max_c;
	logic [7:0]          hi_c, lo_c, rg_min;

	// Stage 1: channel maximum, minimum and which channel wins.
	always_comb begin
		if (red >= green && red >= blue) begin
			max_c = rhsl_pkg::MAX_RED;
			hi_c  = red;
		end else if (green >= blue) begin
			max_c = rhsl_pkg::MAX_GREEN;
			hi_c  = green;
		end else begin
			max_c = rhsl_pkg::MAX_BLUE;
			hi_c  = blue;
		end
		rg_min = (red < green) ? red : green;
		lo_c   = (rg_min < blue) ? rg_min : blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			hi_s1  <= hi_c;
			lo_s1  <= lo_c;
			max_s1 <= max_c;
		end
	end

	// Stage 2: lightness, divisors and rounded dividends.
	logic [8:0]            sum, sum_p1, den_sat;
	logic [7:0]            spread;
	rhsl_pkg::rhsl_tag_t   tag_c;
	rhsl_pkg::rhsl_lanes_t lanes_c;

	function automatic logic [15:0] delta_num(input logic [7:0] d, input logic [7:0] half);
		return 16'(16'(d) * 16'(rhsl_pkg::HUE_STEP)) + 16'(half);
	endfunction

	always_comb begin
		sum     = {1'b0, hi_s1} + {1'b0, lo_s1};
		sum_p1  = sum + 9'd1;
		spread  = hi_s1 - lo_s1;
		den_sat = (sum <= rhsl_pkg::SUM_DARK_MAX) ? sum : (rhsl_pkg::SUM_FULL - sum);

		tag_c.valid   = valid_s1;
		tag_c.grey    = (hi_s1 == lo_s1);
		tag_c.max_sel = max_s1;
		tag_c.light   = sum_p1[8:1];

		lanes_c[rhsl_pkg::LANE_SAT].rem = 16'(16'(spread) * 16'(rhsl_pkg::SCALE_MAX))
			+ 16'(den_sat[8:1]);
		lanes_c[rhsl_pkg::LANE_SAT].den = den_sat;
		lanes_c[rhsl_pkg::LANE_SAT].quo = '0;

		lanes_c[rhsl_pkg::LANE_DR].rem = delta_num(hi_s1 - r_s1, {1'b0, spread[7:1]});
		lanes_c[rhsl_pkg::LANE_DG].rem = delta_num(hi_s1 - g_s1, {1'b0, spread[7:1]});
		lanes_c[rhsl_pkg::LANE_DB].rem = delta_num(hi_s1 - b_s1, {1'b0, spread[7:1]});
		lanes_c[rhsl_pkg::LANE_DR].den = {1'b0, spread};
		lanes_c[rhsl_pkg::LANE_DG].den = {1'b0, spread};
		lanes_c[rhsl_pkg::LANE_DB].den = {1'b0, spread};
		lanes_c[rhsl_pkg::LANE_DR].quo = '0;
		lanes_c[rhsl_pkg::LANE_DG].quo = '0;
		lanes_c[rhsl_pkg::LANE_DB].quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_s2 <= lanes_c;
		end
	end

endmodule

### design/rhsl_div_stage.sv
`timescale 1ns / 1ps
module rhsl_div_stage #(
	parameter int unsigned STAGE = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  rhsl_pkg::rhsl_tag_t   tag,
	input  rhsl_pkg::rhsl_lanes_t lanes,
	output rhsl_pkg::rhsl_tag_t   tag_sn,
	output rhsl_pkg::rhsl_lanes_t lanes_sn
);

	// Quotient bits resolved here, most significant first.
	localparam logic [2:0] BIT_HI =
		3'(rhsl_pkg::QUO_W - 1 - rhsl_pkg::BITS_PER_STAGE * STAGE);
	localparam logic [2:0] BIT_LO = BIT_HI - 3'd1;

	rhsl_pkg::rhsl_lanes_t lanes_c;

	always_comb begin
		for (int i = 0; i < rhsl_pkg::NUM_LANES; i++) begin
			lanes_c[i] = rhsl_pkg::rhsl_div_bit(rhsl_pkg::rhsl_div_bit(lanes[i], BIT_HI), BIT_LO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sn <= '0;
		end else if (adv) begin
			tag_sn <= tag;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_sn <= lanes_c;
		end
	end

endmodule

### design/rhsl_hue.sv
`timescale 1ns / 1ps
module rhsl_hue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  rhsl_pkg::rhsl_tag_t   tag,
	input  rhsl_pkg::rhsl_lanes_t lanes,
	output logic                  valid_s7,
	output logic [7:0]            hue_s7,
	output logic [7:0]            sat_s7,
	output logic [7:0]            light_s7
);

	logic [7:0] dr, dg, db, hue_c, sat_c;

	// Hue is the sector base plus the difference of the two other deltas, modulo 256; grey forces it to zero.
	always_comb begin
		dr = lanes[rhsl_pkg::LANE_DR].quo;
		dg = lanes[rhsl_pkg::LANE_DG].quo;
		db = lanes[rhsl_pkg::LANE_DB].quo;
		case (tag.max_sel)
			rhsl_pkg::MAX_RED:   hue_c = db - dg;
			rhsl_pkg::MAX_GREEN: hue_c = rhsl_pkg::HUE_GREEN + dr - db;
			rhsl_pkg::MAX_BLUE:  hue_c = rhsl_pkg::HUE_BLUE + dg - dr;
			default:             hue_c = '0;
		endcase
		sat_c = lanes[rhsl_pkg::LANE_SAT].quo;
		if (tag.grey) begin
			hue_c = '0;
			sat_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s7   <= hue_c;
			sat_s7   <= sat_c;
			light_s7 <= tag.light;
		end
	end

endmodule

### design/rgb_to_hsl_integer_unit.sv
`timescale 1ns / 1ps
// Channel   Role    Fields (bits)
// rgb       sink    red (8), green (8), blue (8)
// hsl       source  hue (8), saturation (8), lightness (8)
//
// Seven register stages: min/max, dividends, four divider stages of two
// quotient bits each, and the hue/output register. One item enters per cycle
// while the pipeline does not hold. Reset clears the valid bits and the
// control that travels with them. When a result waits and hsl is not ready,
// the whole pipeline holds, and rgb.ready drops in the same cycle.
module rgb_to_hsl_integer_unit (
	input  logic        clk,
	input  logic        arst_n,
	rhsl_rgb_if.sink    rgb,
	rhsl_hsl_if.source  hsl
);

	// The pipeline advances as one whenever the output register is empty or
	// its item is being taken this cycle.
	logic adv;
	logic out_valid;

	assign adv       = !out_valid || hsl.ready;
	assign rgb.ready = adv;

	rhsl_pkg::rhsl_tag_t   tags  [rhsl_pkg::DIV_STAGES+1];
	rhsl_pkg::rhsl_lanes_t lanes [rhsl_pkg::DIV_STAGES+1];

	// Stages 1 and 2: find the extreme channels, then form lightness, the
	// saturation divisor and the rounded dividends for the four divisions.
	rhsl_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid    (rgb.valid),
		.red      (rgb.red),
		.green    (rgb.green),
		.blue     (rgb.blue),
		.tag_s2   (tags[0]),
		.lanes_s2 (lanes[0])
	);

	// Stages 3 to 6: restoring division, saturation and three hue deltas in
	// parallel lanes, two quotient bits per stage.
	for (genvar s = 0; s < rhsl_pkg::DIV_STAGES; s++) begin : g_div
		rhsl_div_stage #(
			.STAGE (s)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.tag      (tags[s]),
			.lanes    (lanes[s]),
			.tag_sn   (tags[s+1]),
			.lanes_sn (lanes[s+1])
		);
	end

	// Stage 7: hue from the sector of the maximum channel, grey override, and
	// the output register.
	rhsl_hue u_hue (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tag      (tags[rhsl_pkg::DIV_STAGES]),
		.lanes    (lanes[rhsl_pkg::DIV_STAGES]),
		.valid_s7 (out_valid),
		.hue_s7   (hsl.hue),
		.sat_s7   (hsl.saturation),
		.light_s7 (hsl.lightness)
	);

	assign hsl.valid = out_valid;

endmodule

### test/rgb_to_hsl_integer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the RGB to HSL pixel converter. The bench predicts
// each result from the accepted pixel and checks results strictly in order.
module rgb_to_hsl_integer_unit_tb;

	// Upper bound on consecutive cycles in which neither channel moves an item.
	// The longest legal quiet stretch is a sender gap plus a receiver stall
	// plus the pipeline depth, which stays far below this limit.
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned RANDOM_PIXELS = 1850;
	localparam int unsigned QUIET_PIXELS  = 300;

	typedef struct {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] lightness;
	} hsl_t;

	// Holds the HSL values still owed by the converter, oldest first, and
	// keeps a few counts of which corners of the conversion were reached.
	class hsl_scoreboard;
		hsl_t        pending_hsl[$];
		int unsigned mismatches;
		int unsigned pixels;
		int unsigned results;
		int unsigned greys;
		int unsigned dark_pixels;
		int unsigned light_pixels;
		int unsigned wrapped_hues;

		function new();
			mismatches   = 0;
			pixels       = 0;
			results      = 0;
			greys        = 0;
			dark_pixels  = 0;
			light_pixels = 0;
			wrapped_hues = 0;
		endfunction

		// Integer HSL conversion. Hue deltas and saturation use rounded
		// division; lightness rounds half up. A negative hue wraps modulo 256.
		function hsl_t predict_hsl(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int   hi, lo, sum, light, spread, den, dr, dg, db, hue;
			int   sat;
			hsl_t res;
			hi = r;
			if (g > hi) hi = g;
			if (b > hi) hi = b;
			lo = r;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			sum   = hi + lo;
			light = (sum * 255 + 255) / 510;
			sat   = 0;
			hue   = 0;
			if (hi == lo) begin
				greys++;
			end else begin
				spread = hi - lo;
				if (light <= 127) begin
					den = sum;
					dark_pixels++;
				end else begin
					den = 510 - sum;
					light_pixels++;
				end
				if (den == 0) den = 1;
				sat = (spread * 255 + den / 2) / den;
				dr  = ((hi - r) * int'(rhsl_pkg::HUE_STEP) + spread / 2) / spread;
				dg  = ((hi - g) * int'(rhsl_pkg::HUE_STEP) + spread / 2) / spread;
				db  = ((hi - b) * int'(rhsl_pkg::HUE_STEP) + spread / 2) / spread;
				if (r == hi)
					hue = db - dg;
				else if (g == hi)
					hue = int'(rhsl_pkg::HUE_GREEN) + dr - db;
				else
					hue = int'(rhsl_pkg::HUE_BLUE) + dg - dr;
				if (hue < 0 || hue > 255) wrapped_hues++;
			end
			res.hue        = hue[7:0];
			res.saturation = sat[7:0];
			res.lightness  = light[7:0];
			return res;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			pending_hsl.push_back(predict_hsl(r, g, b));
			pixels++;
		endfunction

		function void check_result(logic [7:0] h, logic [7:0] s, logic [7:0] l);
			hsl_t want;
			results++;
			if (pending_hsl.size() == 0) begin
				$error("result with no pixel outstanding: hue %0d saturation %0d lightness %0d",
					h, s, l);
				mismatches++;
				return;
			end
			want = pending_hsl.pop_front();
			if (h !== want.hue) begin
				$error("hue mismatch: expected %0d, actual %0d", want.hue, h);
				mismatches++;
			end
			if (s !== want.saturation) begin
				$error("saturation mismatch: expected %0d, actual %0d", want.saturation, s);
				mismatches++;
			end
			if (l !== want.lightness) begin
				$error("lightness mismatch: expected %0d, actual %0d", want.lightness, l);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_hsl.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rhsl_rgb_if rgb_bus ();
	rhsl_hsl_if hsl_bus ();

	hsl_scoreboard hsl_sb = new();

	// Set once the run enters its final stretch, where neither side idles.
	bit          steady_phase;
	int unsigned idle_cycles;

	rgb_to_hsl_integer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb_bus),
		.hsl    (hsl_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side. The check runs at the clock edge, so it sees the handshake
	// exactly as the converter does: outputs and ready from before the edge.
	always @(posedge clk) begin
		if (arst_n && hsl_bus.valid && hsl_bus.ready)
			hsl_sb.check_result(hsl_bus.hue, hsl_bus.saturation, hsl_bus.lightness);
	end

	// Receiver back-pressure: short runs of ready, now and then broken by a
	// stall of random length. In the steady phase ready simply stays high.
	initial begin
		hsl_bus.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!steady_phase && $urandom_range(0, 3) == 0) begin
				hsl_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			hsl_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Watchdog: any cycle that moves an item on either channel resets the
	// count. A stuck handshake or a lost result ends the run here.
	initial begin
		idle_cycles = 0;
		@(posedge clk iff arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((rgb_bus.valid && rgb_bus.ready) || (hsl_bus.valid && hsl_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("rgb_to_hsl_integer_unit_tb NOT OK");
		$finish;
	end

	// Offers one pixel and holds it until the converter takes it. Valid stays
	// high on return, so back-to-back pixels follow without a gap.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		rgb_bus.valid <= 1'b1;
		rgb_bus.red   <= r;
		rgb_bus.green <= g;
		rgb_bus.blue  <= b;
		do @(posedge clk); while (!rgb_bus.ready);
		hsl_sb.note_pixel(r, g, b);
	endtask

	// Drops valid for a gap whose length the caller gives; the payload carries
	// junk meanwhile so a converter that samples it without valid is caught.
	task automatic hold_off(input int unsigned cycles);
		rgb_bus.valid <= 1'b0;
		rgb_bus.red   <= 8'($urandom);
		rgb_bus.green <= 8'($urandom);
		rgb_bus.blue  <= 8'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Picks one channel value near the edges of the range or the midpoint.
	function automatic logic [7:0] edge_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Random pixel drawn from a mix of shapes: mostly uniform, plus greys,
	// edge levels and pixels whose channels differ by at most three steps,
	// which stress the rounding of the small divisors.
	task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
		output logic [7:0] b);
		int unsigned shape;
		logic [7:0]  base;
		shape = $urandom_range(0, 9);
		if (shape < 6) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
		end else if (shape == 6) begin
			r = 8'($urandom);
			g = r;
			b = r;
		end else if (shape < 9) begin
			r = edge_level();
			g = edge_level();
			b = edge_level();
		end else begin
			base = 8'($urandom_range(0, 252));
			r = base + 8'($urandom_range(0, 3));
			g = base + 8'($urandom_range(0, 3));
			b = base + 8'($urandom_range(0, 3));
		end
	endtask

	initial begin
		logic [7:0] r, g, b;
		arst_n        = 1'b0;
		steady_phase  = 1'b0;
		rgb_bus.valid <= 1'b0;
		rgb_bus.red   <= 8'd0;
		rgb_bus.green <= 8'd0;
		rgb_bus.blue  <= 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels: black and white, the primaries and secondaries
		// (which also tie two channels at the maximum), a mid grey, a red
		// maximum whose hue goes negative and wraps, the smallest possible
		// dark divisor and light divisor, and the pair of sums on either
		// side of the dark/light split.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd10);
		send_pixel(8'd200, 8'd3, 8'd90);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd200, 8'd54, 8'd100);
		send_pixel(8'd200, 8'd55, 8'd100);
		send_pixel(8'd10, 8'd20, 8'd30);
		send_pixel(8'd240, 8'd250, 8'd230);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd1, 8'd254, 8'd128);
		hold_off(3);

		for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
			// Halfway through, the sender waits for the pipeline to empty
			// completely before it offers anything more.
			if (n == RANDOM_PIXELS / 2) begin
				rgb_bus.valid <= 1'b0;
				@(posedge clk);
				while (hsl_sb.outstanding() != 0) @(posedge clk);
			end
			if (n == RANDOM_PIXELS - QUIET_PIXELS)
				steady_phase = 1'b1;
			if (!steady_phase && $urandom_range(0, 4) == 0)
				hold_off($urandom_range(1, 10));
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		rgb_bus.valid <= 1'b0;

		// Drain: wait for every owed result, then keep clocking for DRAIN_CYCLES
		// so a spurious extra result would still be seen.
		while (hsl_sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (hsl_sb.outstanding() != 0) begin
			$error("%0d results never arrived", hsl_sb.outstanding());
			hsl_sb.mismatches++;
		end

		$display("Converted %0d pixels into %0d results: %0d grey, %0d dark, %0d light.",
			hsl_sb.pixels, hsl_sb.results, hsl_sb.greys, hsl_sb.dark_pixels,
			hsl_sb.light_pixels);
		$display("Hue wrapped below zero %0d times; both channels idled at random.",
			hsl_sb.wrapped_hues);
		if (hsl_sb.mismatches == 0) begin
			$display("rgb_to_hsl_integer_unit_tb OK");
		end else begin
			$display("rgb_to_hsl_integer_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

### files.f
design/rhsl_pkg.sv
design/rhsl_rgb_if.sv
design/rhsl_hsl_if.sv
design/rhsl_prep.sv
design/rhsl_div_stage.sv
design/rhsl_hue.sv
design/rgb_to_hsl_integer_unit.sv
test/rgb_to_hsl_integer_unit_tb.sv
